// ===== rtl/wac_pkg.sv =====
// Shared constants, register codes and payload types of the waypoint arrival check.
package wac_pkg;

    // Fixed point
    localparam int FRACTION_BITS = 8;
    localparam int HALF_TURN     = 180 * (2 ** FRACTION_BITS);
    localparam int FULL_TURN     = 360 * (2 ** FRACTION_BITS);

    // Field widths
    localparam int POS_W  = 24;
    localparam int OFS_W  = 25;
    localparam int TOL_W  = 23;
    localparam int TIME_W = 32;
    localparam int HERR_W = 17;
    localparam int DIST_W = 25;
    localparam int OPT_W  = 2;

    // Biased heading value: always positive, reduced modulo a full turn
    localparam int HV_W      = 26;
    localparam int HV_W1     = HV_W + 1;
    localparam int WRAP_BIAS = ((2 ** POS_W) / FULL_TURN + 1) * FULL_TURN;
    localparam int MOD_STEPS = $clog2((2 ** HV_W) / FULL_TURN + 1);

    // Square root pipeline, one root bit per stage
    localparam int SQ_W        = 2 * POS_W;
    localparam int SQRT_STAGES = DIST_W;
    localparam int RAD_W       = 2 * SQRT_STAGES;
    localparam int REM_W       = SQRT_STAGES + 2;

    // Queue between front and back (power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int REG_AW  = 3;
    localparam int PADDR_W = REG_AW + 2;

    localparam logic [REG_AW-1:0] REG_TARGET_X       = 3'd0;
    localparam logic [REG_AW-1:0] REG_TARGET_Y       = 3'd1;
    localparam logic [REG_AW-1:0] REG_TARGET_HEADING = 3'd2;
    localparam logic [REG_AW-1:0] REG_HEADING_TOL    = 3'd3;
    localparam logic [REG_AW-1:0] REG_LINEAR_TOL     = 3'd4;
    localparam logic [REG_AW-1:0] REG_TIMEOUT_LIMIT  = 3'd5;
    localparam logic [REG_AW-1:0] REG_START_TIME     = 3'd6;
    localparam logic [REG_AW-1:0] REG_OPTION_ENABLES = 3'd7;

    // Option enable bits
    localparam int OPT_HEADING = 0;
    localparam int OPT_TIMEOUT = 1;

    // Stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic signed [POS_W-1:0]  target_x;
        logic signed [POS_W-1:0]  target_y;
        logic signed [POS_W-1:0]  target_heading;
        logic        [TOL_W-1:0]  heading_tolerance;
        logic        [TOL_W-1:0]  linear_tolerance;
        logic        [TIME_W-1:0] timeout_limit_ms;
        logic        [TIME_W-1:0] start_time_ms;
        logic        [OPT_W-1:0]  option_enables;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0]  pose_x;
        logic signed [POS_W-1:0]  pose_y;
        logic signed [POS_W-1:0]  pose_heading;
        logic        [TIME_W-1:0] now_ms;
    } t_pose;

    // Classified item from front to back
    typedef struct packed {
        logic signed [OFS_W-1:0]  dx;
        logic signed [OFS_W-1:0]  dy;
        logic        [POS_W-1:0]  ux;
        logic        [POS_W-1:0]  uy;
        logic        [HV_W-1:0]   hv;
        logic        [TIME_W-1:0] elapsed;
        logic                     head_on;
        logic                     time_on;
    } t_item;

    // Fields riding alongside the square root
    typedef struct packed {
        logic signed [OFS_W-1:0]  dx;
        logic signed [OFS_W-1:0]  dy;
        logic        [HV_W-1:0]   hv;
        logic                     timed_out;
        logic        [TIME_W-1:0] remaining;
        logic                     head_on;
        logic                     time_on;
    } t_side;

    typedef struct packed {
        logic signed [OFS_W-1:0]  offset_x;
        logic signed [OFS_W-1:0]  offset_y;
        logic        [DIST_W-1:0] distance;
        logic signed [HERR_W-1:0] heading_error;
        logic                     heading_valid;
        logic                     timed_out;
        logic        [TIME_W-1:0] remaining_ms;
        logic                     remaining_valid;
        logic                     reached;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== rtl/wac_front.sv =====
// Front stage: accepts a pose, forms offsets, biased heading error and elapsed time.
module wac_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wac_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  wac_pkg::t_pose      i_pose,
    input  wac_pkg::t_fifo_stat i_fifo,
    output logic                o_push,
    output wac_pkg::t_item      o_item
);
    import wac_pkg::*;

    logic                    r_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic signed [OFS_W-1:0] w_dx;
    logic signed [OFS_W-1:0] w_dy;
    logic signed [OFS_W-1:0] w_he;
    logic signed [HV_W:0]    w_hsum;

    // Offsets and heading difference, one sign-extended subtract each
    assign w_dx = OFS_W'($signed(i_cfg.target_x)) - OFS_W'($signed(i_pose.pose_x));
    assign w_dy = OFS_W'($signed(i_cfg.target_y)) - OFS_W'($signed(i_pose.pose_y));
    assign w_he = OFS_W'($signed(i_cfg.target_heading)) - OFS_W'($signed(i_pose.pose_heading));

    // Bias the heading error by a half turn plus whole turns so it stays positive
    assign w_hsum = HV_W1'(w_he) + HV_W1'(HALF_TURN + WRAP_BIAS);

    always_comb begin
        n_item.dx      = w_dx;
        n_item.dy      = w_dy;
        n_item.ux      = w_dx[OFS_W-1] ? POS_W'(-w_dx) : POS_W'(w_dx);
        n_item.uy      = w_dy[OFS_W-1] ? POS_W'(-w_dy) : POS_W'(w_dy);
        n_item.hv      = w_hsum[HV_W-1:0];
        n_item.elapsed = i_pose.now_ms - i_cfg.start_time_ms;
        n_item.head_on = i_cfg.option_enables[OPT_HEADING];
        n_item.time_on = i_cfg.option_enables[OPT_TIMEOUT];
    end

    // Hand off to the queue whenever it has room
    assign o_ready = !r_valid || !i_fifo.full;
    assign o_push  = r_valid && !i_fifo.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the classified transaction
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/wac_fifo.sv =====
// Short register queue that decouples the front stage from the back pipeline.
module wac_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wac_pkg::t_item      i_item,
    input  logic                i_pop,
    output wac_pkg::t_fifo_stat o_stat,
    output wac_pkg::t_item      o_item
);
    import wac_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full && !i_pop |-> !i_push)
        else $error("queue written while full");
`endif

endmodule

// ===== rtl/wac_sqrt.sv =====
// Pipelined floor square root, one root bit resolved per stage.
module wac_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [wac_pkg::RAD_W-1:0]    i_rad,
    output logic [wac_pkg::DIST_W-1:0]   o_root
);
    import wac_pkg::*;

    logic [REM_W-1:0]       r_rem  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] r_root [SQRT_STAGES];
    logic [RAD_W-1:0]       r_rad  [SQRT_STAGES];
    logic [REM_W-1:0]       n_rem  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] n_root [SQRT_STAGES];
    logic [RAD_W-1:0]       n_rad  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]       w_rem_in;
        logic [SQRT_STAGES-1:0] w_root_in;
        logic [RAD_W-1:0]       w_rad_in;
        logic [REM_W+1:0]       w_rs;
        logic [REM_W+1:0]       w_trial;
        logic [REM_W+1:0]       w_diff;
        logic                   w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        // Bring down two radicand bits and try root*4+1
        assign w_rs    = {w_rem_in, w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_diff  = w_rs - w_trial;
        assign w_ge    = (w_rs >= w_trial);

        assign n_rem[k]  = w_ge ? w_diff[REM_W-1:0] : w_rs[REM_W-1:0];
        assign n_root[k] = {w_root_in[SQRT_STAGES-2:0], w_ge};
        assign n_rad[k]  = {w_rad_in[RAD_W-3:0], 2'b00};
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

// ===== rtl/wac_back.sv =====
// Back pipeline: squares, timeout check, square root, heading wrap and tolerance checks.
module wac_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wac_pkg::t_cfg       i_cfg,
    input  wac_pkg::t_fifo_stat i_fifo,
    input  wac_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output wac_pkg::t_result    o_result
);
    import wac_pkg::*;

    logic                   w_adv;
    logic                   r_v0;
    logic                   r_v1;
    logic [SQRT_STAGES-1:0] r_vs;
    logic                   r_out_valid;

    logic [SQ_W-1:0]        r_sqx;
    logic [SQ_W-1:0]        r_sqy;
    t_side                  r_side0;
    t_side                  n_side0;
    logic [RAD_W-1:0]       r_rad;
    t_side                  r_side1;
    t_side                  r_ss [SQRT_STAGES];
    t_side                  n_ss [SQRT_STAGES];
    logic [DIST_W-1:0]      w_root;
    t_side                  w_last;
    logic signed [HERR_W-1:0] w_herr;
    logic [HERR_W-1:0]      w_mag;
    logic                   w_ang_ok;
    logic                   w_lin_ok;
    t_result                r_out;
    t_result                n_out;
    logic                   w_tmo;

    // Whole pipeline moves unless the output register is held
    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && !i_fifo.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_vs        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v0        <= o_pop;
            r_v1        <= r_v0;
            r_vs        <= {r_vs[SQRT_STAGES-2:0], r_v1};
            r_out_valid <= r_vs[SQRT_STAGES-1];
        end
    end

    // Timeout check against the limit
    assign w_tmo = (i_item.elapsed >= i_cfg.timeout_limit_ms);

    always_comb begin
        n_side0.dx        = i_item.dx;
        n_side0.dy        = i_item.dy;
        n_side0.hv        = i_item.hv;
        n_side0.head_on   = i_item.head_on;
        n_side0.time_on   = i_item.time_on;
        n_side0.timed_out = i_item.time_on && w_tmo;
        n_side0.remaining = (i_item.time_on && !w_tmo) ?
                            (i_cfg.timeout_limit_ms - i_item.elapsed) : '0;
    end

    // Square both offsets, then sum into the radicand
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqx   <= SQ_W'(i_item.ux) * SQ_W'(i_item.ux);
            r_sqy   <= SQ_W'(i_item.uy) * SQ_W'(i_item.uy);
            r_side0 <= n_side0;
            r_rad   <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
            r_side1 <= r_side0;
        end
    end

    wac_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // Carry side fields with the root; reduce heading modulo a full turn on the way
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_side
        t_side w_in;

        if (k == 0) begin : g_first
            assign w_in = r_side1;
        end else begin : g_next
            assign w_in = r_ss[k-1];
        end

        if (k < MOD_STEPS) begin : g_mod
            localparam logic [HV_W:0] STEP_SUB =
                HV_W1'(FULL_TURN * (2 ** (MOD_STEPS - 1 - k)));
            always_comb begin
                n_ss[k] = w_in;
                if ({1'b0, w_in.hv} >= STEP_SUB) begin
                    n_ss[k].hv = HV_W'({1'b0, w_in.hv} - STEP_SUB);
                end
            end
        end else begin : g_pass
            assign n_ss[k] = w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_ss[k] <= n_ss[k];
            end
        end
    end

    // Unbias heading, check tolerances, form the result
    assign w_last   = r_ss[SQRT_STAGES-1];
    assign w_herr   = HERR_W'(w_last.hv) - HERR_W'(HALF_TURN);
    assign w_mag    = w_herr[HERR_W-1] ? HERR_W'(-w_herr) : HERR_W'(w_herr);
    assign w_ang_ok = !w_last.head_on || (TOL_W'(w_mag) <= i_cfg.heading_tolerance);
    assign w_lin_ok = (w_root <= DIST_W'(i_cfg.linear_tolerance));

    always_comb begin
        n_out.offset_x        = w_last.dx;
        n_out.offset_y        = w_last.dy;
        n_out.distance        = w_root;
        n_out.heading_error   = w_last.head_on ? w_herr : '0;
        n_out.heading_valid   = w_last.head_on;
        n_out.timed_out       = w_last.timed_out;
        n_out.remaining_ms    = w_last.remaining;
        n_out.remaining_valid = w_last.time_on;
        n_out.reached         = w_lin_ok && w_ang_ok;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_herr_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.heading_valid |-> r_out.heading_error == '0)
        else $error("heading error nonzero with heading disabled");

    a_herr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out.heading_error) >= -HERR_W'(HALF_TURN))
                     && ($signed(r_out.heading_error) < HERR_W'(HALF_TURN)))
        else $error("heading error outside half turn");

    a_timeout_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.timed_out || !r_out.remaining_valid)
            |-> r_out.remaining_ms == '0 && (r_out.remaining_valid || !r_out.timed_out))
        else $error("timeout fields inconsistent");
`endif

endmodule

// ===== rtl/waypoint_arrival_check_core.sv =====
// Top level of the waypoint arrival check: configuration registers, stream ports, pipeline.
// Throughput: one pose per cycle while the output is not stalled; the 25-stage square root
// pipeline, one root bit per stage, makes up most of the pipeline depth, and a 4-entry
// queue after the front stage absorbs output stalls. Reset (synchronous, active low) clears
// the configuration registers to zero and empties the pipeline.
module waypoint_arrival_check_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wac_pkg::PADDR_W-1:0]      paddr,
    input  logic [wac_pkg::APB_DW-1:0]       pwdata,
    output logic [wac_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pose_x[23:0], pose_y[47:24], pose_heading[71:48], now_ms[103:72]
    input  logic [wac_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // offset_x[24:0], offset_y[49:25], distance[74:50], heading_error[91:75],
    // timed_out[92], remaining_ms[124:93], reached[125], zero[127:126]
    output logic [wac_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // heading_valid[0], remaining_valid[1]
    output logic [wac_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import wac_pkg::*;

    t_cfg              r_cfg;
    logic              w_wr;
    logic [REG_AW-1:0] w_idx;
    t_pose             w_pose;
    t_item             w_front_item;
    t_item             w_fifo_item;
    t_fifo_stat        w_fifo_stat;
    logic              w_push;
    logic              w_pop;
    t_result           w_res;

    // Register writes on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TARGET_X:       r_cfg.target_x          <= pwdata[POS_W-1:0];
                REG_TARGET_Y:       r_cfg.target_y          <= pwdata[POS_W-1:0];
                REG_TARGET_HEADING: r_cfg.target_heading    <= pwdata[POS_W-1:0];
                REG_HEADING_TOL:    r_cfg.heading_tolerance <= pwdata[TOL_W-1:0];
                REG_LINEAR_TOL:     r_cfg.linear_tolerance  <= pwdata[TOL_W-1:0];
                REG_TIMEOUT_LIMIT:  r_cfg.timeout_limit_ms  <= pwdata[TIME_W-1:0];
                REG_START_TIME:     r_cfg.start_time_ms     <= pwdata[TIME_W-1:0];
                REG_OPTION_ENABLES: r_cfg.option_enables    <= pwdata[OPT_W-1:0];
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (w_idx)
            REG_TARGET_X:       prdata = APB_DW'(r_cfg.target_x);
            REG_TARGET_Y:       prdata = APB_DW'(r_cfg.target_y);
            REG_TARGET_HEADING: prdata = APB_DW'(r_cfg.target_heading);
            REG_HEADING_TOL:    prdata = APB_DW'(r_cfg.heading_tolerance);
            REG_LINEAR_TOL:     prdata = APB_DW'(r_cfg.linear_tolerance);
            REG_TIMEOUT_LIMIT:  prdata = APB_DW'(r_cfg.timeout_limit_ms);
            REG_START_TIME:     prdata = APB_DW'(r_cfg.start_time_ms);
            REG_OPTION_ENABLES: prdata = APB_DW'(r_cfg.option_enables);
        endcase
    end

    // Unpack the input transaction
    always_comb begin
        w_pose.pose_x       = s_axis_tdata[23:0];
        w_pose.pose_y       = s_axis_tdata[47:24];
        w_pose.pose_heading = s_axis_tdata[71:48];
        w_pose.now_ms       = s_axis_tdata[103:72];
    end

    wac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pose  (w_pose),
        .i_fifo  (w_fifo_stat),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    wac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_stat  (w_fifo_stat),
        .o_item  (w_fifo_item)
    );

    wac_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fifo   (w_fifo_stat),
        .i_item   (w_fifo_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    // Pack the output transaction
    assign m_axis_tdata = {2'b00,
                           w_res.reached,
                           w_res.remaining_ms,
                           w_res.timed_out,
                           w_res.heading_error,
                           w_res.distance,
                           w_res.offset_y,
                           w_res.offset_x};
    assign m_axis_tuser = {w_res.remaining_valid, w_res.heading_valid};

endmodule

// ===== tb/waypoint_arrival_check_core_tb.sv =====
// Self-checking testbench for the waypoint arrival check core: APB setup, pose stream, scoreboard.
module waypoint_arrival_check_core_tb;
    import wac_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_POSES  = 58;

    // Expected-result store and arrival predictor
    class arrival_scoreboard;
        t_cfg    cfg;
        t_result pending_results[$];
        int      mismatches;

        function new();
            cfg        = '0;
            mismatches = 0;
        endfunction

        // Mirror a register write, truncated to the register width
        function void set_reg(logic [REG_AW-1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_TARGET_X:       cfg.target_x          = value[POS_W-1:0];
                REG_TARGET_Y:       cfg.target_y          = value[POS_W-1:0];
                REG_TARGET_HEADING: cfg.target_heading    = value[POS_W-1:0];
                REG_HEADING_TOL:    cfg.heading_tolerance = value[TOL_W-1:0];
                REG_LINEAR_TOL:     cfg.linear_tolerance  = value[TOL_W-1:0];
                REG_TIMEOUT_LIMIT:  cfg.timeout_limit_ms  = value[TIME_W-1:0];
                REG_START_TIME:     cfg.start_time_ms     = value[TIME_W-1:0];
                REG_OPTION_ENABLES: cfg.option_enables    = value[OPT_W-1:0];
                default: ;
            endcase
        endfunction

        // Build the root one bit at a time from the top
        function logic [DIST_W-1:0] floor_root(longint unsigned v);
            logic [DIST_W-1:0] root;
            logic [DIST_W-1:0] trial;
            root = '0;
            for (int b = DIST_W - 1; b >= 0; b--) begin
                trial = root | (DIST_W'(1) << b);
                if (64'(trial) * 64'(trial) <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function t_result predict_arrival(t_pose p);
            t_result           r;
            longint            dx, dy, e, w, herr;
            longint unsigned   ux, uy, mag;
            logic [TIME_W-1:0] elapsed;
            logic              ang_ok;
            r  = '0;
            dx = longint'($signed(cfg.target_x)) - longint'($signed(p.pose_x));
            dy = longint'($signed(cfg.target_y)) - longint'($signed(p.pose_y));
            ux = (dx < 0) ? -dx : dx;
            uy = (dy < 0) ? -dy : dy;
            r.offset_x = dx[OFS_W-1:0];
            r.offset_y = dy[OFS_W-1:0];
            r.distance = floor_root(ux * ux + uy * uy);
            ang_ok     = 1'b1;

            // Wrap heading error into [-180,180)
            if (cfg.option_enables[OPT_HEADING]) begin
                e = longint'($signed(cfg.target_heading)) - longint'($signed(p.pose_heading));
                w = (e + HALF_TURN) % FULL_TURN;
                if (w < 0) begin
                    w = w + FULL_TURN;
                end
                herr = w - HALF_TURN;
                mag  = (herr < 0) ? -herr : herr;
                r.heading_error = herr[HERR_W-1:0];
                r.heading_valid = 1'b1;
                ang_ok = (mag <= cfg.heading_tolerance);
            end

            // Elapsed time wraps modulo 2^32
            if (cfg.option_enables[OPT_TIMEOUT]) begin
                elapsed = p.now_ms - cfg.start_time_ms;
                r.remaining_valid = 1'b1;
                if (elapsed >= cfg.timeout_limit_ms) begin
                    r.timed_out = 1'b1;
                end else begin
                    r.remaining_ms = cfg.timeout_limit_ms - elapsed;
                end
            end

            r.reached = (r.distance <= cfg.linear_tolerance) && ang_ok;
            return r;
        endfunction

        // Append the predicted result behind the older ones
        function void note_pose(t_pose p);
            pending_results = {pending_results, predict_arrival(p)};
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        // Compare one output transaction against the oldest pending result
        task check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            t_result               want;
            logic [M_TDATA_W-1:0]  wd;
            if (pending_results.size() == 0) begin
                report_mismatch("output transaction with no pose pending");
                return;
            end
            want = pending_results.pop_front();
            wd = {2'b00, want.reached, want.remaining_ms, want.timed_out, want.heading_error,
                  want.distance, want.offset_y, want.offset_x};
            compare_field("offset_x",        tdata[24:0],    wd[24:0]);
            compare_field("offset_y",        tdata[49:25],   wd[49:25]);
            compare_field("distance",        tdata[74:50],   wd[74:50]);
            compare_field("heading_error",   tdata[91:75],   wd[91:75]);
            compare_field("timed_out",       tdata[92],      wd[92]);
            compare_field("remaining_ms",    tdata[124:93],  wd[124:93]);
            compare_field("reached",         tdata[125],     wd[125]);
            compare_field("tdata pad",       tdata[127:126], wd[127:126]);
            compare_field("heading_valid",   tuser[0],       want.heading_valid);
            compare_field("remaining_valid", tuser[1],       want.remaining_valid);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    arrival_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    waypoint_arrival_check_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("waypoint_arrival_check_core verification failed");
            $finish;
        end
    end

    // Accept output transactions and randomize back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Write one register: setup cycle, access cycle, then release the bus
    task automatic program_reg(logic [REG_AW-1:0] idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_all(logic [31:0] tx, logic [31:0] ty, logic [31:0] th,
                               logic [31:0] htol, logic [31:0] ltol, logic [31:0] limit,
                               logic [31:0] start, logic [31:0] opts);
        program_reg(REG_TARGET_X, tx);
        program_reg(REG_TARGET_Y, ty);
        program_reg(REG_TARGET_HEADING, th);
        program_reg(REG_HEADING_TOL, htol);
        program_reg(REG_LINEAR_TOL, ltol);
        program_reg(REG_TIMEOUT_LIMIT, limit);
        program_reg(REG_START_TIME, start);
        program_reg(REG_OPTION_ENABLES, opts);
    endtask

    // Present one pose, hold until accepted, then maybe go idle
    task automatic send_pose(t_pose p);
        s_axis_tdata  <= {p.now_ms, p.pose_heading, p.pose_y, p.pose_x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pose(p);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_pose pose_of(logic [23:0] x, logic [23:0] y, logic [23:0] h,
                                      logic [31:0] now);
        t_pose p;
        p.pose_x       = x;
        p.pose_y       = y;
        p.pose_heading = h;
        p.now_ms       = now;
        return p;
    endfunction

    function automatic logic [31:0] pick_signed();
        case ($urandom_range(3))
            0:       return 32'h007F_FFFF;
            1:       return 32'hFF80_0000;
            2:       return 32'($urandom_range(0, 8191)) - 32'd4096;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_span(logic [31:0] mask);
        case ($urandom_range(3))
            0:       return '0;
            1:       return mask;
            2:       return 32'($urandom_range(0, 8191));
            default: return $urandom() & mask;
        endcase
    endfunction

    // Half the poses near the target, the rest anywhere in range; times near the start, the deadline or anywhere
    function automatic t_pose make_pose();
        t_pose p;
        if ($urandom_range(1)) begin
            p.pose_x = sb.cfg.target_x - 24'($urandom_range(0, 2048)) + 24'd1024;
            p.pose_y = sb.cfg.target_y - 24'($urandom_range(0, 2048)) + 24'd1024;
            p.pose_heading = sb.cfg.target_heading - 24'($urandom_range(0, 1024)) + 24'd512
                           + 24'(FULL_TURN * $urandom_range(0, 3));
        end else begin
            p.pose_x       = $urandom();
            p.pose_y       = $urandom();
            p.pose_heading = $urandom();
        end
        case ($urandom_range(2))
            0:       p.now_ms = $urandom();
            1:       p.now_ms = sb.cfg.start_time_ms + 32'($urandom_range(0, 4000));
            default: p.now_ms = sb.cfg.start_time_ms + sb.cfg.timeout_limit_ms
                              + 32'($urandom_range(0, 4)) - 32'd2;
        endcase
        return p;
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: every option off, zero tolerances
        send_pose(pose_of(24'h000000, 24'h000000, 24'h000000, 32'h0000_0000));
        send_pose(pose_of(24'h7FFFFF, 24'h800000, 24'h123456, 32'hFFFF_FFFF));
        wait_drained();

        // Max target, zero timeout limit, zero heading tolerance, heading exactly opposite
        program_all(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 32'h0, 32'h007F_FFFF,
                    32'h0, 32'h0, (1 << OPT_HEADING) | (1 << OPT_TIMEOUT));
        send_pose(pose_of(24'h800000, 24'h800000, 24'h800000, 32'h0000_0000));
        send_pose(pose_of(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF));
        send_pose(pose_of(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF - 24'(HALF_TURN), 32'h1234));
        send_pose(pose_of(24'h000000, 24'h7FFFFF, 24'h000000, 32'h8000_0000));
        wait_drained();

        // Min target, wide heading tolerance, start time just before the clock wraps
        program_all(32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, 32'h007F_FFFF, 32'h0,
                    32'd1000, 32'hFFFF_FF00, (1 << OPT_HEADING) | (1 << OPT_TIMEOUT));
        send_pose(pose_of(24'h7FFFFF, 24'h7FFFFF, 24'h800000 + 24'(HALF_TURN), 32'h10));
        send_pose(pose_of(24'h800000, 24'h800000, 24'h800000, 32'hFFFF_FF00 + 32'd999));
        send_pose(pose_of(24'h800000, 24'h7FFFFF, 24'h000000, 32'hFFFF_FF00 + 32'd1000));
        send_pose(pose_of(24'h000000, 24'h800000, 24'h7FFFFF, 32'hFFFF_FEFF));
        send_pose(pose_of(24'h800000, 24'h800000, 24'h800000, 32'hFFFF_FF00));
        wait_drained();

        // Heading only: errors at and just past the tolerance, and across whole turns
        program_all(32'd1000, -32'sd2000, 32'd23040, 32'd1280, 32'd640,
                    32'hFFFF_FFFF, 32'h0, (1 << OPT_HEADING));
        send_pose(pose_of(24'd488, -24'sd1616, 24'd21760, 32'h0));
        send_pose(pose_of(24'd487, -24'sd1616, 24'd24321, 32'h0));
        send_pose(pose_of(24'd1000, -24'sd2000, 24'd24320 - 24'(2 * FULL_TURN), 32'h0));
        wait_drained();

        // Timeout only: elapsed wraps to the maximum, one and the whole limit remaining
        program_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd5,
                    (1 << OPT_TIMEOUT));
        send_pose(pose_of(24'h000000, 24'h000000, 24'h000000, 32'd4));
        send_pose(pose_of(24'h000001, 24'h000000, 24'h000000, 32'd3));
        send_pose(pose_of(24'h000000, 24'hFFFFFF, 24'h000000, 32'd5));
        wait_drained();

        // Random phases, cycling through the flow-control mixes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            program_all(pick_signed(), pick_signed(), pick_signed(),
                        pick_span(32'h007F_FFFF), pick_span(32'h007F_FFFF),
                        pick_span(32'hFFFF_FFFF), $urandom(), $urandom_range(0, 3));
            repeat (PHASE_POSES) send_pose(make_pose());
            wait_drained();
        end

        // Let any stray output transaction surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("waypoint_arrival_check_core verification clean");
        end else begin
            $display("waypoint_arrival_check_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wac_pkg.sv
rtl/wac_front.sv
rtl/wac_fifo.sv
rtl/wac_sqrt.sv
rtl/wac_back.sv
rtl/waypoint_arrival_check_core.sv
tb/waypoint_arrival_check_core_tb.sv
